@@ design/stac_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper target approach controller package
// Shared types, opcodes, register indexes and rate constants.
// ----------------------------------------------------------------------------
package stac_pkg;

	// Default sizing of the block.
	localparam int STAC_SAMPLE_WINDOW = 5;
	localparam int STAC_POSITION_BITS = 16;

	// Fixed field widths.
	localparam int SAMPLE_W = 10;
	localparam int COORD_W  = 16;
	localparam int RATE_W   = 16;
	localparam int LIMIT_W  = 15;
	localparam int SUM_W    = 13;

	// Step rates in hertz.
	localparam logic [RATE_W-1:0] RATE_500    = 16'd500;
	localparam logic [RATE_W-1:0] RATE_1000   = 16'd1000;
	localparam logic [RATE_W-1:0] RATE_1500   = 16'd1500;
	localparam logic [RATE_W-1:0] RATE_2000   = 16'd2000;
	localparam logic [RATE_W-1:0] RATE_2500   = 16'd2500;
	localparam logic [RATE_W-1:0] RATE_3000   = 16'd3000;
	localparam logic [RATE_W-1:0] RATE_STOP   = 16'd0;
	localparam logic [RATE_W-1:0] RATE_BUTTON = 16'd1000;

	// Distance tier boundaries in steps.
	localparam int DIST_T1 = 10;
	localparam int DIST_T2 = 20;
	localparam int DIST_T3 = 40;
	localparam int DIST_T4 = 50;
	localparam int DIST_T5 = 60;

	// Configuration register indexes.
	localparam logic REG_POSITION_LIMIT = 1'b0;
	localparam logic REG_STOP_ON_STALL  = 1'b1;

	typedef enum logic [2:0] {
		OP_INDEX  = 3'd0,
		OP_MOVE   = 3'd1,
		OP_STALL  = 3'd2,
		OP_BUTTON = 3'd3,
		OP_CLEAR  = 3'd4
	} stac_op_t;

	typedef struct packed {
		stac_op_t                   opcode;
		logic [SAMPLE_W-1:0]        load_sample;
		logic signed [COORD_W-1:0]  target_position;
		logic [RATE_W-1:0]          rate_after_move;
		logic                       line_level;
	} stac_item_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] position_limit;
		logic               stop_on_stall;
	} stac_cfg_t;

	typedef struct packed {
		logic [RATE_W-1:0]          step_rate;
		logic                       direction;
		logic signed [COORD_W-1:0]  position;
		logic                       target_active;
		logic                       target_reached;
		logic                       stalled;
		logic signed [COORD_W-1:0]  stall_position;
	} stac_motion_t;

endpackage

@@ design/stepper_target_approach_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper target approach controller
// Valve stepper position controller: one event in, one status result out.
// ----------------------------------------------------------------------------
// An accepted input transaction passes through the input register, then the
// result register, before its result is offered on the master side.
// Throughput: one transaction per cycle while m_tready keeps the result side
// moving; the state update is a single short compare-and-select pass between
// the input register and the result register.
// Reset (arst_n low) empties both registers, zeroes position, target, rates,
// the sample window and its sum, sets the direction to closing, clears the
// position limit and enables stop on stall.
module stepper_target_approach_controller_core #(
	parameter int SAMPLE_WINDOW = stac_pkg::STAC_SAMPLE_WINDOW,
	parameter int POSITION_BITS = stac_pkg::STAC_POSITION_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Slave side: event transactions.
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata, low bit up: load_sample[9:0], target_position[25:10],
	// rate_after_move[41:26], line_level[42], zero fill [47:43].
	input  logic [47:0] s_tdata,
	// s_tuser: opcode[2:0].
	input  logic [2:0]  s_tuser,
	// Master side: result transactions.
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata, low bit up: step_rate[15:0], direction[16], position[32:17],
	// target_active[33], target_reached[34], stalled[35],
	// stall_position[51:36], load_sum[64:52], zero fill [71:65].
	output logic [71:0] m_tdata,
	// Configuration write port.
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [14:0] wr_data
);
	import stac_pkg::*;

	// Configuration registers. They must be written only while the block is idle; the block does not enforce it.
	stac_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.position_limit <= '0;
			cfg_q.stop_on_stall  <= 1'b1;
		end else if (wr_en) begin
			case (wr_index)
				REG_POSITION_LIMIT: cfg_q.position_limit <= wr_data;
				REG_STOP_ON_STALL:  cfg_q.stop_on_stall  <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	// Input register. The item in it is committed to the state in the same
	// cycle that its result is loaded into the result register, so the state
	// never runs ahead of the results that have been produced.
	logic       valid_s1;
	stac_item_t item_s1;
	logic       out_valid_q;
	logic [71:0] out_data_q;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.opcode          <= stac_op_t'(s_tuser);
			item_s1.load_sample     <= s_tdata[9:0];
			item_s1.target_position <= signed'(s_tdata[25:10]);
			item_s1.rate_after_move <= s_tdata[41:26];
			item_s1.line_level      <= s_tdata[42];
		end
	end

	// Event processing: motion state and the load sample window.
	stac_motion_t       motion;
	logic [SUM_W-1:0]   load_sum;
	logic               push;

	assign push = advance && (item_s1.opcode == OP_INDEX);

	stac_motion #(
		.POSITION_BITS(POSITION_BITS)
	) u_motion (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (motion)
	);

	stac_window #(
		.SAMPLE_WINDOW(SAMPLE_WINDOW)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sample (item_s1.load_sample),
		.sum    (load_sum)
	);

	// Result register. It holds a finished result while the input register
	// takes the next transaction, so the two sides are decoupled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= advance || (out_valid_q && !m_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'b0, load_sum, motion.stall_position, motion.stalled,
				motion.target_reached, motion.target_active, motion.position,
				motion.direction, motion.step_rate};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

@@ design/stac_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Load sample window
// Keeps the last samples in a circular buffer and a running sum of them.
// ----------------------------------------------------------------------------
module stac_window #(
	parameter int SAMPLE_WINDOW = stac_pkg::STAC_SAMPLE_WINDOW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic [stac_pkg::SAMPLE_W-1:0] sample,
	output logic [stac_pkg::SUM_W-1:0]    sum
);
	import stac_pkg::*;

	localparam int PTR_W = (SAMPLE_WINDOW > 1) ? $clog2(SAMPLE_WINDOW) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(SAMPLE_WINDOW - 1);

	logic [SAMPLE_W-1:0] win_q [SAMPLE_WINDOW];
	logic [PTR_W-1:0]    ptr_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    sum_d;

	// The sum wraps at its width, so subtracting the oldest sample is exact.
	assign sum_d = sum_q - SUM_W'(win_q[ptr_q]) + SUM_W'(sample);
	assign sum   = push ? sum_d : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SAMPLE_WINDOW; i++) begin
				win_q[i] <= '0;
			end
			ptr_q <= '0;
			sum_q <= '0;
		end else if (push) begin
			win_q[ptr_q] <= sample;
			ptr_q        <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
			sum_q        <= sum_d;
		end
	end

endmodule

@@ design/stac_motion.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motion state and approach logic
// Position, direction, target, rate, button and stall state per event.
// ----------------------------------------------------------------------------
module stac_motion #(
	parameter int POSITION_BITS = stac_pkg::STAC_POSITION_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   commit,
	input  stac_pkg::stac_item_t   item,
	input  stac_pkg::stac_cfg_t    cfg,
	output stac_pkg::stac_motion_t result
);
	import stac_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int XW = (PB > COORD_W) ? PB : COORD_W;
	localparam int CW = XW + 1;
	localparam logic signed [PB-1:0] POS_MAX = {1'b0, {(PB-1){1'b1}}};
	localparam logic signed [PB-1:0] POS_MIN = {1'b1, {(PB-1){1'b0}}};

	logic signed [PB-1:0]      pos_q, pos_d;
	logic                      dir_q, dir_d;
	logic [LIMIT_W-1:0]        tgt_q, tgt_d;
	logic                      tval_q, tval_d;
	logic [RATE_W-1:0]         frate_q, frate_d;
	logic [RATE_W-1:0]         rate_q, rate_d;
	logic                      held_q, held_d;
	logic                      sflag_q, sflag_d;
	logic signed [COORD_W-1:0] slatch_q, slatch_d;

	logic [LIMIT_W-1:0]        clamp_v;
	logic signed [XW-1:0]      pos_now_x, pos_new_x;
	logic signed [CW-1:0]      ap_pos_x, ap_tgt_x, clamp_x;
	logic signed [CW:0]        ap_diff;
	logic [CW:0]               ap_dist;
	logic                      ap_hit;
	logic                      run_approach;
	logic                      reached;

	// Target clamp: negative goes to zero, above a nonzero limit to the limit.
	always_comb begin
		if (item.target_position[COORD_W-1]) begin
			clamp_v = '0;
		end else if (cfg.position_limit != '0 &&
				item.target_position[LIMIT_W-1:0] > cfg.position_limit) begin
			clamp_v = cfg.position_limit;
		end else begin
			clamp_v = item.target_position[LIMIT_W-1:0];
		end
	end

	assign pos_now_x = XW'(pos_q);
	assign clamp_x   = signed'(CW'(clamp_v));

	always_comb begin
		pos_d        = pos_q;
		dir_d        = dir_q;
		tgt_d        = tgt_q;
		tval_d       = tval_q;
		frate_d      = frate_q;
		rate_d       = rate_q;
		held_d       = held_q;
		sflag_d      = sflag_q;
		slatch_d     = slatch_q;
		run_approach = 1'b0;
		reached      = 1'b0;

		case (item.opcode)
			OP_INDEX: begin
				if (dir_q) begin
					if (pos_q > POS_MIN) pos_d = pos_q - PB'(1);
				end else begin
					if (pos_q < POS_MAX) pos_d = pos_q + PB'(1);
				end
				run_approach = 1'b1;
			end
			OP_MOVE: begin
				tgt_d        = clamp_v;
				tval_d       = 1'b1;
				frate_d      = item.rate_after_move;
				dir_d        = (CW'(pos_q) < clamp_x) ? 1'b0 : 1'b1;
				run_approach = 1'b1;
			end
			OP_STALL: begin
				if (item.line_level && cfg.stop_on_stall) begin
					rate_d   = RATE_STOP;
					sflag_d  = 1'b1;
					slatch_d = pos_now_x[COORD_W-1:0];
					pos_d    = '0;
				end
			end
			OP_BUTTON: begin
				if (!item.line_level && !held_q) begin
					held_d = 1'b1;
					dir_d  = ~dir_q;
					rate_d = RATE_BUTTON;
				end else if (item.line_level && held_q) begin
					held_d = 1'b0;
				end
			end
			OP_CLEAR: begin
				sflag_d = 1'b0;
			end
			default: begin
			end
		endcase

		// Rate selection by distance left, on the updated position and target.
		ap_pos_x = CW'(pos_d);
		ap_tgt_x = signed'(CW'(tgt_d));
		ap_diff  = (CW+1)'(ap_pos_x) - (CW+1)'(ap_tgt_x);
		ap_dist  = ap_diff[CW] ? unsigned'(-ap_diff) : unsigned'(ap_diff);
		ap_hit   = dir_d ? (ap_pos_x <= ap_tgt_x) : (ap_pos_x >= ap_tgt_x);

		if (run_approach) begin
			if (!tval_d) begin
				rate_d = RATE_3000;
			end else if (ap_hit) begin
				rate_d  = frate_d;
				tval_d  = 1'b0;
				reached = 1'b1;
			end else if (ap_dist < (CW+1)'(DIST_T1)) begin
				rate_d = RATE_500;
			end else if (ap_dist < (CW+1)'(DIST_T2)) begin
				rate_d = RATE_1000;
			end else if (ap_dist < (CW+1)'(DIST_T3)) begin
				rate_d = RATE_1500;
			end else if (ap_dist < (CW+1)'(DIST_T4)) begin
				rate_d = RATE_2000;
			end else if (ap_dist < (CW+1)'(DIST_T5)) begin
				rate_d = RATE_2500;
			end else begin
				rate_d = RATE_3000;
			end
		end
	end

	assign pos_new_x = XW'(pos_d);

	always_comb begin
		result.step_rate      = rate_d;
		result.direction      = dir_d;
		result.position       = pos_new_x[COORD_W-1:0];
		result.target_active  = tval_d;
		result.target_reached = reached;
		result.stalled        = sflag_d;
		result.stall_position = slatch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			dir_q    <= 1'b1;
			tgt_q    <= '0;
			tval_q   <= 1'b0;
			frate_q  <= '0;
			rate_q   <= '0;
			held_q   <= 1'b0;
			sflag_q  <= 1'b0;
			slatch_q <= '0;
		end else if (commit) begin
			pos_q    <= pos_d;
			dir_q    <= dir_d;
			tgt_q    <= tgt_d;
			tval_q   <= tval_d;
			frate_q  <= frate_d;
			rate_q   <= rate_d;
			held_q   <= held_d;
			sflag_q  <= sflag_d;
			slatch_q <= slatch_d;
		end
	end

endmodule

@@ design/stac_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker for the stepper target approach controller
// Watches the top level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module stac_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata
);
	localparam int BIT_ACTIVE  = 33;
	localparam int BIT_REACHED = 34;

	logic       in_acc;
	logic       out_acc;
	logic [1:0] occ_q;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// Transactions accepted but not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 2'd2)
		else $error("more than two transactions held inside the block");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> occ_q != 2'd0)
		else $error("result offered with no transaction outstanding");

	a_reached_drops: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[BIT_REACHED] |-> !m_tdata[BIT_ACTIVE])
		else $error("target still active on the result that reached it");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or was withdrawn");

endmodule

bind stepper_target_approach_controller_core stac_checker u_stac_checker (.*);

@@ bench/stac_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper target approach controller checker
// Watches the event, status and register write channels, keeps its own copy
// of the motion state and compares every status transaction with its forecast.
// ----------------------------------------------------------------------------
module tb_stac_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [71:0] m_tdata,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [14:0] wr_data,
	output int          mismatches,
	output int          waiting,
	output int          observed
);
	import stac_pkg::*;

	typedef struct packed {
		logic [RATE_W-1:0]         step_rate;
		logic                      direction;
		logic signed [COORD_W-1:0] position;
		logic                      target_active;
		logic                      target_reached;
		logic                      stalled;
		logic signed [COORD_W-1:0] stall_position;
		logic [SUM_W-1:0]          load_sum;
	} status_t;

	localparam logic signed [COORD_W-1:0] POS_TOP    = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] POS_BOTTOM = 16'sh8000;

	logic [LIMIT_W-1:0]        limit_q;
	logic                      stop_q;
	logic signed [COORD_W-1:0] pos_q;
	logic                      dir_q;
	logic signed [COORD_W-1:0] goal_q;
	logic                      goal_valid_q;
	logic [RATE_W-1:0]         final_rate_q;
	logic [RATE_W-1:0]         rate_q;
	logic [SAMPLE_W-1:0]       window_q [STAC_SAMPLE_WINDOW];
	int                        slot_q;
	int                        sum_q;
	logic                      held_q;
	logic                      stall_q;
	logic signed [COORD_W-1:0] latch_q;

	status_t status_queue [$];
	status_t got;
	status_t want;
	int      fail_n;
	int      result_n;
	int      i;

	// Rate tier by remaining distance; drops the target once it is passed or met.
	function automatic bit close_in();
		int span;
		bit hit;
		if (!goal_valid_q) begin
			rate_q = RATE_3000;
			return 1'b0;
		end
		hit = dir_q ? (pos_q <= goal_q) : (pos_q >= goal_q);
		if (hit) begin
			rate_q = final_rate_q;
			goal_valid_q = 1'b0;
			return 1'b1;
		end
		span = int'(pos_q) - int'(goal_q);
		if (span < 0)
			span = -span;
		if (span < DIST_T1)
			rate_q = RATE_500;
		else if (span < DIST_T2)
			rate_q = RATE_1000;
		else if (span < DIST_T3)
			rate_q = RATE_1500;
		else if (span < DIST_T4)
			rate_q = RATE_2000;
		else if (span < DIST_T5)
			rate_q = RATE_2500;
		else
			rate_q = RATE_3000;
		return 1'b0;
	endfunction

	function automatic status_t apply_event(input logic [2:0] op, input logic [47:0] data);
		logic [SAMPLE_W-1:0] sample;
		int                  target;
		logic [RATE_W-1:0]   after;
		logic                level;
		bit                  reached;
		status_t             res;
		sample  = data[9:0];
		target  = int'($signed(data[25:10]));
		after   = data[41:26];
		level   = data[42];
		reached = 1'b0;
		case (op)
			OP_INDEX: begin
				if (dir_q) begin
					if (pos_q != POS_BOTTOM)
						pos_q = pos_q - 16'sd1;
				end else if (pos_q != POS_TOP) begin
					pos_q = pos_q + 16'sd1;
				end
				sum_q = sum_q - int'(window_q[slot_q]) + int'(sample);
				window_q[slot_q] = sample;
				slot_q = (slot_q + 1) % STAC_SAMPLE_WINDOW;
				reached = close_in();
			end
			OP_MOVE: begin
				if (limit_q != '0 && target > int'(limit_q))
					target = int'(limit_q);
				if (target < 0)
					target = 0;
				goal_q = target[15:0];
				goal_valid_q = 1'b1;
				final_rate_q = after;
				dir_q = (int'(pos_q) < target) ? 1'b0 : 1'b1;
				reached = close_in();
			end
			OP_STALL: begin
				if (level && stop_q) begin
					rate_q = RATE_STOP;
					stall_q = 1'b1;
					latch_q = pos_q;
					pos_q = '0;
				end
			end
			OP_BUTTON: begin
				if (!level && !held_q) begin
					held_q = 1'b1;
					dir_q = ~dir_q;
					rate_q = RATE_BUTTON;
				end else if (level && held_q) begin
					held_q = 1'b0;
				end
			end
			OP_CLEAR: begin
				stall_q = 1'b0;
			end
			default: ;
		endcase
		res.step_rate      = rate_q;
		res.direction      = dir_q;
		res.position       = pos_q;
		res.target_active  = goal_valid_q;
		res.target_reached = reached;
		res.stalled        = stall_q;
		res.stall_position = latch_q;
		res.load_sum       = sum_q[SUM_W-1:0];
		return res;
	endfunction

	task automatic check_field(input string label, input logic [31:0] want_v,
		input logic [31:0] got_v);
		if (want_v !== got_v) begin
			fail_n++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q = '0;
			stop_q = 1'b1;
			pos_q = '0;
			dir_q = 1'b1;
			goal_q = '0;
			goal_valid_q = 1'b0;
			final_rate_q = '0;
			rate_q = '0;
			for (i = 0; i < STAC_SAMPLE_WINDOW; i++)
				window_q[i] = '0;
			slot_q = 0;
			sum_q = 0;
			held_q = 1'b0;
			stall_q = 1'b0;
			latch_q = '0;
			status_queue.delete();
			fail_n = 0;
			result_n = 0;
			mismatches <= 0;
			waiting <= 0;
			observed <= 0;
		end else begin
			// Results leave before this edge's event is forecast, so a stray
			// result can never consume a fresh expectation.
			if (m_tvalid && m_tready) begin
				got.step_rate      = m_tdata[15:0];
				got.direction      = m_tdata[16];
				got.position       = m_tdata[32:17];
				got.target_active  = m_tdata[33];
				got.target_reached = m_tdata[34];
				got.stalled        = m_tdata[35];
				got.stall_position = m_tdata[51:36];
				got.load_sum       = m_tdata[64:52];
				if (status_queue.size() == 0) begin
					fail_n++;
					$display("%0t: unexpected status, expected none, actual %0h", $time,
						m_tdata);
				end else begin
					want = status_queue.pop_front();
					result_n++;
					check_field("step_rate", want.step_rate, got.step_rate);
					check_field("direction", want.direction, got.direction);
					check_field("position", want.position, got.position);
					check_field("target_active", want.target_active, got.target_active);
					check_field("target_reached", want.target_reached, got.target_reached);
					check_field("stalled", want.stalled, got.stalled);
					check_field("stall_position", want.stall_position, got.stall_position);
					check_field("load_sum", want.load_sum, got.load_sum);
				end
			end
			if (wr_en) begin
				if (wr_index == REG_POSITION_LIMIT)
					limit_q = wr_data;
				else
					stop_q = wr_data[0];
			end
			if (s_tvalid && s_tready)
				status_queue.push_back(apply_event(s_tuser, s_tdata));
			mismatches <= fail_n;
			waiting <= status_queue.size();
			observed <= result_n;
		end
	end

endmodule

@@ bench/tb_stepper_target_approach_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper target approach controller regression
// Drives directed and random event streams through the controller under
// several register settings, with random idling on both stream sides, and
// lets the checker compare every status transaction with its forecast.
// ----------------------------------------------------------------------------
module tb_stepper_target_approach_controller_core;
	import stac_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        wr_en = 1'b0;
	logic        wr_index = 1'b0;
	logic [14:0] wr_data = '0;

	int mismatches;
	int waiting;
	int observed;
	int sent = 0;
	int settings = 0;
	int rx_hold = 0;
	// When set, neither side idles; the closing stretch of the run uses it.
	bit quiet = 1'b0;

	// 2 ns clock period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stepper_target_approach_controller_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	tb_stac_checker monitor (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.mismatches (mismatches),
		.waiting    (waiting),
		.observed   (observed)
	);

	// Result side back-pressure: occasional stalls of random length.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			rx_hold = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Load readings lean toward the ends of the range so the window sum
	// sees both zero and full scale.
	function automatic logic [SAMPLE_W-1:0] load_reading();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [RATE_W-1:0] rate_value();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return RATE_W'($urandom);
		endcase
	endfunction

	// One event transaction. Valid stays high between back-to-back events, and
	// an idle burst only lowers it in a step where nothing else drives it.
	task automatic send_event(input logic [2:0] op, input logic [SAMPLE_W-1:0] sample,
		input logic signed [COORD_W-1:0] target, input logic [RATE_W-1:0] after,
		input logic level);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, level, after, target, sample};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	// Drains the pipeline: the checker's count of outstanding results is
	// registered, hence the wait on the clock before looking at it.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers, written one after the other while the block is idle.
	task automatic set_config(input logic [LIMIT_W-1:0] limit, input logic stop);
		wr_en <= 1'b1;
		wr_index <= REG_POSITION_LIMIT;
		wr_data <= limit;
		@(posedge clk);
		wr_index <= REG_STOP_ON_STALL;
		wr_data <= {14'b0, stop};
		@(posedge clk);
		wr_en <= 1'b0;
		settings++;
	endtask

	// Mostly approach runs: a move to a nearby target followed by a stream of
	// index pulses, so every rate tier and the arrival are exercised. The rest
	// is button presses, stall activity and fully random noise events.
	task automatic random_traffic(input int count);
		int n;
		int pick;
		int goal;
		int steps;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 9);
			if (pick < 6) begin
				if ($urandom_range(0, 9) == 0)
					goal = $urandom;
				else
					goal = $urandom_range(0, 150) - 10;
				send_event(OP_MOVE, SAMPLE_W'($urandom), COORD_W'(goal), rate_value(),
					1'($urandom));
				steps = $urandom_range(1, 120);
				repeat (steps)
					send_event(OP_INDEX, load_reading(), COORD_W'($urandom),
						RATE_W'($urandom), 1'($urandom));
				n += steps + 1;
			end else if (pick == 6) begin
				send_event(OP_BUTTON, SAMPLE_W'($urandom), COORD_W'($urandom),
					RATE_W'($urandom), 1'b0);
				repeat ($urandom_range(0, 4))
					send_event(OP_INDEX, load_reading(), COORD_W'($urandom),
						RATE_W'($urandom), 1'($urandom));
				send_event(OP_BUTTON, SAMPLE_W'($urandom), COORD_W'($urandom),
					RATE_W'($urandom), 1'b1);
				n += 2;
			end else if (pick == 7) begin
				send_event(OP_STALL, SAMPLE_W'($urandom), COORD_W'($urandom),
					RATE_W'($urandom), 1'($urandom));
				if ($urandom_range(0, 1) == 1)
					send_event(OP_CLEAR, SAMPLE_W'($urandom), COORD_W'($urandom),
						RATE_W'($urandom), 1'($urandom));
				n += 1;
			end else begin
				send_event(3'($urandom_range(0, 7)), load_reading(), COORD_W'($urandom),
					rate_value(), 1'($urandom));
				n += 1;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with the reset values written back explicitly.
		set_config(15'd0, 1'b1);
		// Five full-scale loads fill the window to its maximum sum; unused
		// fields are all ones here to show that they are ignored.
		repeat (5) send_event(OP_INDEX, 10'h3FF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_event(OP_INDEX, 10'h000, 16'h0000, 16'h0000, 1'b0);
		// Approach from below: the last pulses run through the nearest tier and
		// arrive, which applies the after-move rate and drops the target.
		send_event(OP_MOVE, 10'h3FF, 16'sd0, 16'hFFFF, 1'b1);
		repeat (6) send_event(OP_INDEX, 10'h155, 16'h7FFF, 16'h0000, 1'b0);
		// A move to the current position arrives at once, closing.
		send_event(OP_MOVE, 10'h000, 16'sd0, 16'h0000, 1'b0);
		// A negative target clamps to zero.
		send_event(OP_MOVE, 10'h000, 16'sh8000, 16'd1234, 1'b0);
		// Largest target with no upper clamp, then stall handling keeps it held.
		send_event(OP_MOVE, 10'h000, 16'sh7FFF, 16'h0000, 1'b0);
		send_event(OP_STALL, 10'h000, 16'h0000, 16'h0000, 1'b0);
		send_event(OP_STALL, 10'h000, 16'h0000, 16'h0000, 1'b1);
		send_event(OP_STALL, 10'h3FF, 16'hFFFF, 16'hFFFF, 1'b1);
		// Button press reverses once; repeats of either level change nothing.
		send_event(OP_BUTTON, 10'h000, 16'h0000, 16'h0000, 1'b0);
		send_event(OP_BUTTON, 10'h000, 16'h0000, 16'h0000, 1'b0);
		send_event(OP_BUTTON, 10'h000, 16'h0000, 16'h0000, 1'b1);
		send_event(OP_BUTTON, 10'h000, 16'h0000, 16'h0000, 1'b1);
		send_event(OP_CLEAR, 10'h3FF, 16'hFFFF, 16'hFFFF, 1'b1);
		// Undefined opcodes leave the state alone.
		send_event(3'd5, 10'h3FF, 16'hFFFF, 16'hFFFF, 1'b1);
		send_event(3'd6, 10'h000, 16'h0000, 16'h0000, 1'b0);
		send_event(3'd7, 10'h2AA, 16'h5555, 16'hAAAA, 1'b1);
		wait_idle();

		// Random phases over a spread of limits and stall behavior.
		set_config(15'h7FFF, 1'b0);
		random_traffic(400);
		wait_idle();
		set_config(15'd60, 1'b1);
		random_traffic(400);
		wait_idle();
		set_config(15'd1, 1'b1);
		random_traffic(230);
		wait_idle();
		set_config(LIMIT_W'($urandom), 1'($urandom));
		random_traffic(370);
		wait_idle();

		// Closing stretch at full rate on both sides.
		set_config(15'd25, 1'b0);
		quiet = 1'b1;
		random_traffic(370);
		wait_idle();
		repeat (10) @(posedge clk);

		$display("Sent %0d event transactions under %0d register settings, with idling",
			sent, settings);
		$display("on both sides and a full-rate finish; %0d status transactions were checked.",
			observed);
		if (mismatches == 0) begin
			$display("stepper_target_approach_controller_core regression: pass");
		end else begin
			$display("stepper_target_approach_controller_core regression: fail");
		end
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("stepper_target_approach_controller_core regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
design/stac_pkg.sv
design/stac_window.sv
design/stac_motion.sv
design/stepper_target_approach_controller_core.sv
design/stac_checker.sv
bench/stac_checker.sv
bench/tb_stepper_target_approach_controller_core.sv
